// ===== rtl/pst_pkg.sv =====
// shared types and constants of the plunge stage metric tracker
// no dependencies
package pst_pkg;

    localparam int FractionBitsDefault = 16;
    localparam int MulSteps = 33;
    localparam int DivSteps = 66;
    localparam int CntW = $clog2(DivSteps);
    localparam int AddrW = 5;

    localparam logic [2:0] RegUpper = 3'd0;
    localparam logic [2:0] RegLower = 3'd1;
    localparam logic [2:0] RegDepth = 3'd2;
    localparam logic [2:0] RegDist  = 3'd3;
    localparam logic [2:0] RegPlunge = 3'd4;
    localparam logic [2:0] RegForge = 3'd5;

    localparam logic OpSample = 1'b0;
    localparam logic OpFinish = 1'b1;

    typedef struct packed {
        logic signed [31:0] upper_threshold;
        logic signed [31:0] lower_threshold;
        logic signed [31:0] depth_limit;
        logic [30:0]        plunge_distance;
        logic [3:0]         plunge_stage_number;
        logic [3:0]         forge_stage_number;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic cross_start;
        logic sel;
        logic mul_step;
        logic div_load;
        logic div_step;
        logic cross_write;
        logic prev_update;
        logic vel_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_finish;
        logic need_upper;
        logic need_lower;
        logic vel_needed;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/pst_stream_if.sv =====
// valid/ready channels for samples and metric results
// depends on nothing
interface pst_sample_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [3:0]         stage;
    logic signed [31:0] position;
    logic signed [31:0] load;
    logic signed [31:0] sample_time;
    modport source (output valid, operation, stage, position, load, sample_time, input ready);
    modport sink (input valid, operation, stage, position, load, sample_time, output ready);
endinterface

interface pst_result_if;
    logic               valid;
    logic               ready;
    logic [30:0]        descent_rate;
    logic               velocity_valid;
    logic signed [31:0] min_position;
    logic               min_position_valid;
    logic signed [31:0] max_force;
    logic               max_force_valid;
    modport source (output valid, descent_rate, velocity_valid, min_position,
                    min_position_valid, max_force, max_force_valid, input ready);
    modport sink (input valid, descent_rate, velocity_valid, min_position,
                  min_position_valid, max_force, max_force_valid, output ready);
endinterface

// ===== rtl/pst_ctrl.sv =====
// sequencer of the tracker: evaluation, interpolation and velocity division
// depends on pst_pkg
module pst_ctrl
    import pst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_CHOOSE, S_START, S_MUL, S_DLOAD, S_DIV,
        S_WRITE, S_PREV, S_FIN, S_VDIV, S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            sel_reg, sel_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.is_finish)
                    state_next = S_FIN;
                else
                begin
                    cmd.eval = 1'b1;
                    state_next = S_CHOOSE;
                end
            end
            S_CHOOSE:
            begin
                if (status.need_upper)
                begin
                    sel_next = 1'b0;
                    state_next = S_START;
                end
                else if (status.need_lower)
                begin
                    sel_next = 1'b1;
                    state_next = S_START;
                end
                else
                    state_next = S_PREV;
            end
            S_START:
            begin
                cmd.cross_start = 1'b1;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(MulSteps - 1))
                    state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1))
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.cross_write = 1'b1;
                if (!sel_reg && status.need_lower)
                begin
                    sel_next = 1'b1;
                    state_next = S_START;
                end
                else
                    state_next = S_PREV;
            end
            S_PREV:
            begin
                cmd.prev_update = 1'b1;
                state_next = S_IDLE;
            end
            S_FIN:
            begin
                cnt_next = '0;
                if (status.vel_needed)
                begin
                    cmd.vel_start = 1'b1;
                    state_next = S_VDIV;
                end
                else
                    state_next = S_EMIT;
            end
            S_VDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

endmodule

// ===== rtl/pst_datapath.sv =====
// tracking registers, shift-add multiplier, restoring divider, result register
// depends on pst_pkg
module pst_datapath
    import pst_pkg::*;
#(
    parameter int FRACTION_BITS = FractionBitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               operation,
    input  logic [3:0]         stage,
    input  logic signed [31:0] position,
    input  logic signed [31:0] load,
    input  logic signed [31:0] sample_time,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        descent_rate,
    output logic               velocity_valid,
    output logic signed [31:0] min_position,
    output logic               min_position_valid,
    output logic signed [31:0] max_force,
    output logic               max_force_valid
);

    // held item
    logic               op_reg;
    logic [3:0]         stage_reg;
    logic signed [31:0] pos_reg, load_reg, time_reg;

    // tracking state
    logic               prev_valid_reg;
    logic signed [31:0] prev_pos_reg, prev_time_reg;
    logic               ucf_reg, lcf_reg;
    logic signed [31:0] uct_reg, lct_reg;
    logic               uclf_reg, lclf_reg;
    logic [32:0]        ucld_reg, lcld_reg;
    logic signed [31:0] uclt_reg, lclt_reg;
    logic               pkf_reg, lpf_reg;
    logic signed [31:0] pk_reg, lp_reg;
    logic               need_u_reg, need_l_reg;

    // arithmetic unit
    logic [65:0] acc_reg, mcand_reg, dvd_reg;
    logic [32:0] mplier_reg, divisor_reg, rem_reg;
    logic        neg_reg, dt_zero_reg;

    logic        ov_reg;
    logic [30:0] vel_reg;
    logic        vv_reg, mpv_reg, mfv_reg;
    logic signed [31:0] mp_reg, mf_reg;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    logic plunge, forge, deep;
    logic cross_u, cross_l, direct_u, direct_l;
    logic [32:0] du, dl;
    logic signed [31:0] tu, tl, t_direct_u, t_direct_l;
    logic have_u, have_l;
    logic signed [31:0] tgt;
    logic signed [32:0] num, den, dt, tdiff;
    logic [33:0] rem_s;
    logic        rem_ge;
    logic signed [31:0] interp;

    assign plunge = (stage_reg == cfg.plunge_stage_number);
    assign forge = (stage_reg == cfg.forge_stage_number);
    assign deep = (pos_reg < cfg.depth_limit);

    always_comb
    begin
        cross_u = prev_valid_reg && !ucf_reg && plunge &&
                  ((prev_pos_reg == cfg.upper_threshold) || (pos_reg == cfg.upper_threshold) ||
                   ((prev_pos_reg < cfg.upper_threshold) && (pos_reg > cfg.upper_threshold)) ||
                   ((prev_pos_reg > cfg.upper_threshold) && (pos_reg < cfg.upper_threshold)));
        cross_l = prev_valid_reg && !lcf_reg && plunge &&
                  ((prev_pos_reg == cfg.lower_threshold) || (pos_reg == cfg.lower_threshold) ||
                   ((prev_pos_reg < cfg.lower_threshold) && (pos_reg > cfg.lower_threshold)) ||
                   ((prev_pos_reg > cfg.lower_threshold) && (pos_reg < cfg.lower_threshold)));
        direct_u = (prev_pos_reg == cfg.upper_threshold) || (pos_reg == cfg.upper_threshold);
        direct_l = (prev_pos_reg == cfg.lower_threshold) || (pos_reg == cfg.lower_threshold);
        t_direct_u = (prev_pos_reg == cfg.upper_threshold) ? prev_time_reg : time_reg;
        t_direct_l = (prev_pos_reg == cfg.lower_threshold) ? prev_time_reg : time_reg;
        du = mag33(33'(pos_reg) - 33'(cfg.upper_threshold));
        dl = mag33(33'(pos_reg) - 33'(cfg.lower_threshold));
    end

    assign have_u = ucf_reg || uclf_reg;
    assign have_l = lcf_reg || lclf_reg;
    assign tu = ucf_reg ? uct_reg : uclt_reg;
    assign tl = lcf_reg ? lct_reg : lclt_reg;
    assign tdiff = 33'(tl) - 33'(tu);

    assign tgt = cmd.sel ? cfg.lower_threshold : cfg.upper_threshold;
    assign num = 33'(tgt) - 33'(prev_pos_reg);
    assign den = 33'(pos_reg) - 33'(prev_pos_reg);
    assign dt = 33'(time_reg) - 33'(prev_time_reg);

    assign rem_s = {rem_reg, dvd_reg[65]};
    assign rem_ge = (rem_s >= {1'b0, divisor_reg});
    assign interp = (dt_zero_reg || (dvd_reg == '0)) ? prev_time_reg :
                    (neg_reg ? prev_time_reg - dvd_reg[31:0] : prev_time_reg + dvd_reg[31:0]);

    assign status.is_finish = (op_reg == OpFinish);
    assign status.need_upper = need_u_reg;
    assign status.need_lower = need_l_reg;
    assign status.vel_needed = have_u && have_l && (tu != tl);
    assign status.out_free = !ov_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            stage_reg <= stage;
            pos_reg <= position;
            load_reg <= load;
            time_reg <= sample_time;
        end
        if (cmd.cross_start)
        begin
            acc_reg <= '0;
            mcand_reg <= 66'(mag33(num));
            mplier_reg <= mag33(dt);
            divisor_reg <= mag33(den);
            neg_reg <= num[32] ^ den[32] ^ dt[32];
            dt_zero_reg <= (dt == '0);
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg <= {mcand_reg[64:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[32:1]};
        end
        if (cmd.div_load)
        begin
            dvd_reg <= acc_reg;
            rem_reg <= '0;
        end
        if (cmd.vel_start)
        begin
            dvd_reg <= 66'(cfg.plunge_distance) << FRACTION_BITS;
            divisor_reg <= mag33(tdiff);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? 33'(rem_s - {1'b0, divisor_reg}) : rem_s[32:0];
            dvd_reg <= {dvd_reg[64:0], rem_ge};
        end
        if (cmd.emit)
        begin
            vel_reg <= status.vel_needed ?
                       ((dvd_reg[65:31] != '0) ? 31'h7FFF_FFFF : dvd_reg[30:0]) : '0;
            vv_reg <= status.vel_needed;
            mp_reg <= lpf_reg ? lp_reg : '0;
            mpv_reg <= lpf_reg;
            mf_reg <= pkf_reg ? pk_reg : '0;
            mfv_reg <= pkf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_pos_reg <= '0;
            prev_time_reg <= '0;
            ucf_reg <= 1'b0;
            lcf_reg <= 1'b0;
            uct_reg <= '0;
            lct_reg <= '0;
            uclf_reg <= 1'b0;
            lclf_reg <= 1'b0;
            ucld_reg <= '0;
            lcld_reg <= '0;
            uclt_reg <= '0;
            lclt_reg <= '0;
            pkf_reg <= 1'b0;
            lpf_reg <= 1'b0;
            pk_reg <= '0;
            lp_reg <= '0;
            need_u_reg <= 1'b0;
            need_l_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (cmd.eval)
            begin
                if ((plunge || forge) && deep && (!pkf_reg || (load_reg > pk_reg)))
                begin
                    pkf_reg <= 1'b1;
                    pk_reg <= load_reg;
                end
                if (forge && deep && (!lpf_reg || (pos_reg < lp_reg)))
                begin
                    lpf_reg <= 1'b1;
                    lp_reg <= pos_reg;
                end
                need_u_reg <= cross_u && !direct_u;
                need_l_reg <= cross_l && !direct_l;
                if (cross_u)
                begin
                    ucf_reg <= 1'b1;
                    if (direct_u)
                        uct_reg <= t_direct_u;
                end
                if (cross_l)
                begin
                    lcf_reg <= 1'b1;
                    if (direct_l)
                        lct_reg <= t_direct_l;
                end
                if (plunge && (!uclf_reg || (du < ucld_reg)))
                begin
                    uclf_reg <= 1'b1;
                    ucld_reg <= du;
                    uclt_reg <= time_reg;
                end
                if (plunge && (!lclf_reg || (dl < lcld_reg)))
                begin
                    lclf_reg <= 1'b1;
                    lcld_reg <= dl;
                    lclt_reg <= time_reg;
                end
            end
            if (cmd.cross_write)
            begin
                if (cmd.sel)
                    lct_reg <= interp;
                else
                    uct_reg <= interp;
            end
            if (cmd.prev_update)
            begin
                prev_valid_reg <= plunge;
                if (plunge)
                begin
                    prev_pos_reg <= pos_reg;
                    prev_time_reg <= time_reg;
                end
            end
            if (cmd.emit)
            begin
                prev_valid_reg <= 1'b0;
                prev_pos_reg <= '0;
                prev_time_reg <= '0;
                ucf_reg <= 1'b0;
                lcf_reg <= 1'b0;
                uct_reg <= '0;
                lct_reg <= '0;
                uclf_reg <= 1'b0;
                lclf_reg <= 1'b0;
                ucld_reg <= '0;
                lcld_reg <= '0;
                uclt_reg <= '0;
                lclt_reg <= '0;
                pkf_reg <= 1'b0;
                lpf_reg <= 1'b0;
                pk_reg <= '0;
                lp_reg <= '0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign descent_rate = vel_reg;
    assign velocity_valid = vv_reg;
    assign min_position = mp_reg;
    assign min_position_valid = mpv_reg;
    assign max_force = mf_reg;
    assign max_force_valid = mfv_reg;

endmodule

// ===== rtl/plunge_stage_metric_tracker_unit.sv =====
// top level of the plunge stage metric tracker: register port, sequencer, datapath
// depends on pst_pkg, pst_stream_if, pst_ctrl, pst_datapath
//
// channel      kind         carries
// sample_ch    valid/ready  operation, stage, position, load, sample_time
// result_ch    valid/ready  velocity, minimum position, peak load with flags
// apb          register     six configuration registers at 4*index
//
// a sample that needs interpolation of a threshold crossing runs it in the shared unit
// (33 multiply steps, 66 divide steps) for each such threshold
// a finish runs 66 divide steps in the shared unit when the velocity exists
// a finish waits in place while the previous result has not been taken
// reset clears all tracking state and loads the default registers
module plunge_stage_metric_tracker_unit
    import pst_pkg::*;
#(
    parameter int FRACTION_BITS = FractionBitsDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    pst_sample_if.sink       sample_ch,
    pst_result_if.source     result_ch
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic    wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_threshold <= 32'(3) << FRACTION_BITS;
            cfg_reg.lower_threshold <= 32'(5) << (FRACTION_BITS - 1);
            cfg_reg.depth_limit <= 32'(3) << FRACTION_BITS;
            cfg_reg.plunge_distance <= 31'(1) << (FRACTION_BITS - 1);
            cfg_reg.plunge_stage_number <= 4'd2;
            cfg_reg.forge_stage_number <= 4'd3;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                RegUpper:  cfg_reg.upper_threshold <= pwdata;
                RegLower:  cfg_reg.lower_threshold <= pwdata;
                RegDepth:  cfg_reg.depth_limit <= pwdata;
                RegDist:   cfg_reg.plunge_distance <= pwdata[30:0];
                RegPlunge: cfg_reg.plunge_stage_number <= pwdata[3:0];
                RegForge:  cfg_reg.forge_stage_number <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            RegUpper:  prdata = cfg_reg.upper_threshold;
            RegLower:  prdata = cfg_reg.lower_threshold;
            RegDepth:  prdata = cfg_reg.depth_limit;
            RegDist:   prdata = {1'b0, cfg_reg.plunge_distance};
            RegPlunge: prdata = {28'd0, cfg_reg.plunge_stage_number};
            RegForge:  prdata = {28'd0, cfg_reg.forge_stage_number};
            default:   prdata = '0;
        endcase
    end

    pst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (sample_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pst_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .operation          (sample_ch.operation),
        .stage              (sample_ch.stage),
        .position           (sample_ch.position),
        .load               (sample_ch.load),
        .sample_time        (sample_ch.sample_time),
        .cmd                (cmd),
        .status             (status),
        .out_valid          (result_ch.valid),
        .out_ready          (result_ch.ready),
        .descent_rate       (result_ch.descent_rate),
        .velocity_valid     (result_ch.velocity_valid),
        .min_position       (result_ch.min_position),
        .min_position_valid (result_ch.min_position_valid),
        .max_force          (result_ch.max_force),
        .max_force_valid    (result_ch.max_force_valid)
    );

endmodule

// ===== test/tb_pst_if.sv =====
// testbench knobs for the sample and result channels of the metric tracker
// depends on nothing; the rtl interfaces of rtl/pst_stream_if.sv are used directly
// by the testbench, and this file holds only the tb-side burst/stall knobs
package tb_pst_knobs;
    localparam int MaxBurst = 12;
    localparam int MaxGap = 6;
    localparam int StallPct = 30;
endpackage

// ===== test/tb_top.sv =====
// testbench of plunge_stage_metric_tracker_unit: directed and random samples,
// finish items checked against a predictor of peak load, minimum position and velocity
// depends on pst_pkg, pst_stream_if, tb_pst_knobs and plunge_stage_metric_tracker_unit
module tb_top;
    import pst_pkg::*;
    import tb_pst_knobs::*;

    typedef struct packed {
        logic [30:0]        vel;
        logic               vel_ok;
        logic signed [31:0] min_pos;
        logic               min_ok;
        logic signed [31:0] peak;
        logic               peak_ok;
    } metrics_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pst_sample_if sample_ch ();
    pst_result_if result_ch ();

    plunge_stage_metric_tracker_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_ch(sample_ch.sink), .result_ch(result_ch.source)
    );

    // predictor state
    logic signed [31:0] upper_thr, lower_thr, depth_lim;
    logic [30:0] distance;
    logic [3:0] plunge_no, forge_no;
    bit prev_ok;
    logic signed [31:0] prev_pos, prev_t;
    bit up_x, lo_x, up_c, lo_c, pk_ok, mn_ok;
    logic signed [31:0] up_xt, lo_xt, up_ct, lo_ct, pk, mn;
    logic [32:0] up_cd, lo_cd;

    metrics_t expected_metrics[$];
    int errors;
    int idle_cycles;
    int burst_left;
    bit stall_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] cross_time(logic signed [31:0] p1,
        logic signed [31:0] t1, logic signed [31:0] p2, logic signed [31:0] t2,
        logic signed [31:0] thr);
        longint num, den, dt;
        logic [127:0] prod;
        logic [127:0] q;
        longint mq;
        bit neg;
        if (p1 == thr)
            return t1;
        if (p2 == thr)
            return t2;
        num = longint'(thr) - longint'(p1);
        den = longint'(p2) - longint'(p1);
        dt = longint'(t2) - longint'(t1);
        prod = 128'(num < 0 ? -num : num) * 128'(dt < 0 ? -dt : dt);
        q = prod / 128'(den < 0 ? -den : den);
        mq = longint'(q[63:0]);
        neg = ((num < 0) != (den < 0)) != (dt < 0);
        if (dt == 0 || mq == 0)
            return t1;
        return neg ? 32'(longint'(t1) - mq) : 32'(longint'(t1) + mq);
    endfunction

    task automatic clear_tracking();
        prev_ok = 0; prev_pos = 0; prev_t = 0;
        up_x = 0; lo_x = 0; up_c = 0; lo_c = 0; pk_ok = 0; mn_ok = 0;
        up_xt = 0; lo_xt = 0; up_ct = 0; lo_ct = 0; pk = 0; mn = 0;
        up_cd = 0; lo_cd = 0;
    endtask

    function automatic bit crosses(logic signed [31:0] p1, logic signed [31:0] p2,
        logic signed [31:0] thr);
        return p1 == thr || p2 == thr || (p1 < thr && p2 > thr) || (p1 > thr && p2 < thr);
    endfunction

    task automatic track_sample(logic op, logic [3:0] stg, logic signed [31:0] pos,
        logic signed [31:0] ld, logic signed [31:0] tm);
        metrics_t m;
        bit is_plunge, is_forge, deep;
        longint tu, tl, diff;
        logic [63:0] v;
        logic [32:0] du, dl;
        if (op == OpFinish)
        begin
            m = '0;
            tu = up_x ? up_xt : up_ct;
            tl = lo_x ? lo_xt : lo_ct;
            if ((up_x || up_c) && (lo_x || lo_c) && tu != tl)
            begin
                diff = tl - tu;
                if (diff < 0)
                    diff = -diff;
                v = (64'(distance) << 16) / 64'(diff);
                m.vel = v > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : v[30:0];
                m.vel_ok = 1;
            end
            m.min_ok = mn_ok;
            m.min_pos = mn_ok ? mn : 0;
            m.peak_ok = pk_ok;
            m.peak = pk_ok ? pk : 0;
            expected_metrics.push_back(m);
            clear_tracking();
            return;
        end
        is_plunge = stg == plunge_no;
        is_forge = stg == forge_no;
        deep = pos < depth_lim;
        if ((is_plunge || is_forge) && deep && (!pk_ok || ld > pk))
        begin
            pk_ok = 1; pk = ld;
        end
        if (is_forge && deep && (!mn_ok || pos < mn))
        begin
            mn_ok = 1; mn = pos;
        end
        if (is_plunge)
        begin
            if (prev_ok && !up_x && crosses(prev_pos, pos, upper_thr))
            begin
                up_xt = cross_time(prev_pos, prev_t, pos, tm, upper_thr); up_x = 1;
            end
            if (prev_ok && !lo_x && crosses(prev_pos, pos, lower_thr))
            begin
                lo_xt = cross_time(prev_pos, prev_t, pos, tm, lower_thr); lo_x = 1;
            end
            du = 33'(longint'(pos) - longint'(upper_thr) < 0 ?
                longint'(upper_thr) - longint'(pos) : longint'(pos) - longint'(upper_thr));
            dl = 33'(longint'(pos) - longint'(lower_thr) < 0 ?
                longint'(lower_thr) - longint'(pos) : longint'(pos) - longint'(lower_thr));
            if (!up_c || du < up_cd)
            begin
                up_c = 1; up_cd = du; up_ct = tm;
            end
            if (!lo_c || dl < lo_cd)
            begin
                lo_c = 1; lo_cd = dl; lo_ct = tm;
            end
            prev_ok = 1; prev_pos = pos; prev_t = tm;
        end
        else
            prev_ok = 0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AddrW'({idx, 2'b00}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            RegUpper: upper_thr = val;
            RegLower: lower_thr = val;
            RegDepth: depth_lim = val;
            RegDist: distance = val[30:0];
            RegPlunge: plunge_no = val[3:0];
            RegForge: forge_no = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_metrics.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic send_item(logic op, logic [3:0] stg, logic signed [31:0] pos,
        logic signed [31:0] ld, logic signed [31:0] tm);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, MaxGap);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, MaxBurst);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.operation <= op;
        sample_ch.stage <= stg;
        sample_ch.position <= pos;
        sample_ch.load <= ld;
        sample_ch.sample_time <= tm;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        track_sample(op, stg, pos, ld, tm);
        burst_left--;
    endtask

    task automatic finish_idle();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
        return 32'(longint'(c) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    // plunge descent toward both thresholds, with interleaved forge samples and noise
    task automatic run_sequence(int len);
        logic signed [31:0] pos, t;
        int step;
        pos = near(upper_thr, 200000) + 32'sd131072;
        t = $urandom;
        for (int i = 0; i < len; i++)
        begin
            step = $urandom_range(0, 9);
            if (step < 6)
            begin
                send_item(OpSample, plunge_no, pos, $urandom, t);
                pos = pos - 32'($urandom_range(0, 40000));
            end
            else if (step < 8)
                send_item(OpSample, forge_no, near(depth_lim, 100000), $urandom, t);
            else
                send_item(OpSample, 4'($urandom), $urandom, $urandom, $urandom);
            t = t + 32'($urandom_range(0, 3000)) - 32'($urandom_range(0, 100));
        end
        send_item(OpFinish, 4'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_item(OpFinish, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OpSample, plunge_no, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OpSample, plunge_no, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OpSample, forge_no, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_item(OpFinish, 0, 0, 0, 0);
        send_item(OpSample, plunge_no, upper_thr, 100, 1000);
        send_item(OpSample, plunge_no, lower_thr, 200, 1000);
        send_item(OpFinish, 0, 0, 0, 0);
        send_item(OpSample, plunge_no, upper_thr + 5, 1, 0);
        send_item(OpSample, plunge_no, lower_thr - 5, 2, 32'sh0001_0000);
        send_item(OpSample, 4'hF, 0, 0, 0);
        send_item(OpSample, plunge_no, lower_thr + 7, 3, 32'sh0002_0000);
        send_item(OpFinish, 0, 0, 0, 0);
        send_item(OpSample, plunge_no, upper_thr + 1, 9, 10);
        send_item(OpSample, plunge_no, upper_thr + 1, 9, 11);
        send_item(OpFinish, 0, 0, 0, 0);
        send_item(OpSample, plunge_no, upper_thr + 9, 0, 32'sh7FFF_0000);
        send_item(OpSample, plunge_no, lower_thr - 9, 0, 32'sh8000_0000);
        send_item(OpFinish, 0, 0, 0, 0);
        send_item(OpSample, plunge_no, upper_thr + 3, 0, 5);
        send_item(OpSample, plunge_no, lower_thr - 3, 0, 6);
        send_item(OpFinish, 0, 0, 0, 0);
        finish_idle();
        wait_drained();
    endtask

    task automatic test_shared_stage();
        write_reg(RegForge, 32'(plunge_no));
        for (int i = 0; i < 8; i++)
            send_item(OpSample, plunge_no, near(upper_thr, 300000), $urandom, 32'(i * 4000));
        send_item(OpFinish, 0, 0, 0, 0);
        finish_idle();
        wait_drained();
    endtask

    task automatic test_random(int n);
        int count;
        int len;
        count = 0;
        while (count < n)
        begin
            len = $urandom_range(2, 14);
            run_sequence(len);
            count += len + 1;
        end
        finish_idle();
        wait_drained();
    endtask

    task automatic test_settings();
        write_reg(RegUpper, 32'h7FFF_FFFF);
        write_reg(RegLower, 32'h8000_0000);
        write_reg(RegDepth, 32'h7FFF_FFFF);
        write_reg(RegDist, 32'h7FFF_FFFF);
        write_reg(RegPlunge, 32'hFFFF_FFF0);
        write_reg(RegForge, 32'h0000_000F);
        send_item(OpSample, 0, 32'sh8000_0000, 5, 0);
        send_item(OpSample, 0, 32'sh7FFF_FFFF, 6, 1);
        send_item(OpFinish, 0, 0, 0, 0);
        send_item(OpSample, 0, 0, 5, 0);
        send_item(OpSample, 0, 0, 6, 0);
        send_item(OpFinish, 0, 0, 0, 0);
        finish_idle();
        wait_drained();
        write_reg(RegUpper, 32'sh8000_0000);
        write_reg(RegLower, 32'sh7FFF_FFFF);
        write_reg(RegDepth, 32'sh8000_0000);
        write_reg(RegDist, 0);
        write_reg(RegPlunge, 7);
        write_reg(RegForge, 9);
        test_random(80);
        write_reg(RegUpper, 32'sh0004_0000);
        write_reg(RegLower, 32'sh0001_0000);
        write_reg(RegDepth, 32'sh0002_8000);
        write_reg(RegDist, 32'h0001_0000);
        write_reg(RegPlunge, 1);
        write_reg(RegForge, 1);
        test_random(100);
        write_reg(RegUpper, 32'($urandom));
        write_reg(RegLower, 32'($urandom));
        write_reg(RegDepth, 32'($urandom));
        write_reg(RegDist, 32'($urandom));
        write_reg(RegPlunge, 32'($urandom));
        write_reg(RegForge, 32'($urandom));
        test_random(60);
    endtask

    // result side: stall pattern and comparison
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_metrics.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    metrics_t m;
                    m = expected_metrics.pop_front();
                    if (result_ch.descent_rate !== m.vel)
                    begin
                        $error("descent_rate exp %0d got %0d", m.vel, result_ch.descent_rate);
                        errors++;
                    end
                    if (result_ch.velocity_valid !== m.vel_ok)
                    begin
                        $error("velocity_valid exp %0d got %0d", m.vel_ok,
                            result_ch.velocity_valid);
                        errors++;
                    end
                    if (result_ch.min_position !== m.min_pos)
                    begin
                        $error("min_position exp %0d got %0d", m.min_pos, result_ch.min_position);
                        errors++;
                    end
                    if (result_ch.min_position_valid !== m.min_ok)
                    begin
                        $error("min_position_valid exp %0d got %0d", m.min_ok,
                            result_ch.min_position_valid);
                        errors++;
                    end
                    if (result_ch.max_force !== m.peak)
                    begin
                        $error("max_force exp %0d got %0d", m.peak, result_ch.max_force);
                        errors++;
                    end
                    if (result_ch.max_force_valid !== m.peak_ok)
                    begin
                        $error("max_force_valid exp %0d got %0d", m.peak_ok,
                            result_ch.max_force_valid);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0)
                stall_on <= !stall_on;
            result_ch.ready <= stall_on ? ($urandom_range(0, 99) >= StallPct) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("[plunge_stage_metric_tracker_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        errors = 0; idle_cycles = 0; burst_left = 0; stall_on = 0;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        sample_ch.valid = 0; sample_ch.operation = 0; sample_ch.stage = 0;
        sample_ch.position = 0; sample_ch.load = 0; sample_ch.sample_time = 0;
        result_ch.ready = 1'b1;
        upper_thr = 32'sh0003_0000; lower_thr = 32'sh0002_8000; depth_lim = 32'sh0003_0000;
        distance = 31'h0000_8000; plunge_no = 2; forge_no = 3;
        clear_tracking();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        test_shared_stage();
        test_settings();
        wait_drained();
        if (errors == 0)
            $display("[plunge_stage_metric_tracker_unit] OK");
        else
            $display("[plunge_stage_metric_tracker_unit] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/pst_pkg.sv
rtl/pst_stream_if.sv
rtl/pst_ctrl.sv
rtl/pst_datapath.sv
rtl/plunge_stage_metric_tracker_unit.sv
test/tb_pst_if.sv
test/tb_top.sv
